// ===== rtl/psb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_pkg: shared types and constants for the priority semaphore bank.
// Holds the request and response items, command and status codes, and the
// command and status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int unsigned NumSemaphoresDef = 16;
  localparam int unsigned NumThreadsDef    = 32;
  localparam int unsigned PriorityBitsDef  = 6;
  localparam int unsigned CountBitsDef     = 16;

  localparam logic [2:0] CMD_INIT     = 3'd0;
  localparam logic [2:0] CMD_DOWN     = 3'd1;
  localparam logic [2:0] CMD_TRY_DOWN = 3'd2;
  localparam logic [2:0] CMD_UP       = 3'd3;
  localparam logic [2:0] CMD_PRIO     = 3'd4;

  localparam logic [3:0] ST_ACQUIRED     = 4'd0;
  localparam logic [3:0] ST_QUEUED       = 4'd1;
  localparam logic [3:0] ST_TRY_FAILED   = 4'd2;
  localparam logic [3:0] ST_UP_NO_WAITER = 4'd3;
  localparam logic [3:0] ST_UP_WOKE      = 4'd4;
  localparam logic [3:0] ST_QUEUE_FULL   = 4'd5;
  localparam logic [3:0] ST_INITIALIZED  = 4'd6;
  localparam logic [3:0] ST_UP_SATURATED = 4'd7;
  localparam logic [3:0] ST_PRIO_UPDATED = 4'd8;
  localparam logic [3:0] ST_NOT_WAITING  = 4'd9;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  sema_id;
    logic [4:0]  thread_id;
    logic [5:0]  priority_req;
    logic [15:0] init_value;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [4:0]  woken_thread;
    logic [5:0]  woken_priority;
    logic        preempt;
    logic [15:0] count_after;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic scan_init; // clear scan state
    logic scan_step; // examine one waiter slot
    logic commit;    // apply the command and build the response
  } psb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last; // the slot under examination is the last one
  } psb_stat_t;

endpackage

// ===== rtl/psb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_ctrl: sequencer of the priority semaphore bank.
// Accepts one item, walks the waiter table, commits, then holds the result.
// ----------------------------------------------------------------------------
module psb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output psb_pkg::psb_cmd_t cmd_o,
  input  psb_pkg::psb_stat_t stat_i
);
  import psb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_OUT    = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   in_fire, out_fire;

  // A new item may enter while the previous result is taken.
  assign out_valid_o = (state_q == S_OUT);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((state_q == S_IDLE) || out_fire);
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.load      = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          if (in_fire) begin
            cmd_o.load      = 1'b1;
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_commit_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o) else $error("commit without result");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_COMMIT) |-> in_stall_o)
    else $error("accepted item while busy");

endmodule

// ===== rtl/psb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_dp: datapath of the priority semaphore bank.
// Holds counts, waiter table and arrival counter; scans one slot per cycle.
// ----------------------------------------------------------------------------
module psb_dp #(
  parameter int unsigned NumSemaphores = psb_pkg::NumSemaphoresDef,
  parameter int unsigned NumThreads    = psb_pkg::NumThreadsDef,
  parameter int unsigned PriorityBits  = psb_pkg::PriorityBitsDef,
  parameter int unsigned CountBits     = psb_pkg::CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psb_pkg::req_t      req_i,
  input  psb_pkg::psb_cmd_t  cmd_i,
  output psb_pkg::psb_stat_t stat_o,
  output psb_pkg::rsp_t      rsp_o
);
  import psb_pkg::*;

  localparam int unsigned SW = (NumSemaphores > 1) ? $clog2(NumSemaphores) : 1;
  localparam int unsigned TW = (NumThreads > 1) ? $clog2(NumThreads) : 1;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  logic [CountBits-1:0]    cnt_q   [NumSemaphores];
  logic [NumThreads-1:0]   wvalid_q;
  logic [SW-1:0]           wsema_q [NumThreads];
  logic [PriorityBits-1:0] wprio_q [NumThreads];
  logic [31:0]             wstamp_q[NumThreads];
  logic [31:0]             arrival_q;

  logic [2:0]              cmd_q;
  logic [SW-1:0]           sema_q;
  logic [4:0]              tid_q;
  logic [PriorityBits-1:0] prio_q;
  logic [15:0]             init_q;

  logic [TW-1:0]           idx_q;
  logic                    found_q;
  logic [TW-1:0]           best_q;
  logic [PriorityBits-1:0] best_prio_q;
  logic [31:0]             best_age_q;
  rsp_t                    rsp_q, rsp_d;

  logic [SW-1:0]           sema_map [16];
  logic [SW-1:0]           sema_in;
  logic [31:0]             age;
  logic                    better, match, has_slot;
  logic [CountBits-1:0]    cur;
  logic [CountBits-1:0]    init_sat;

  // Semaphore ids beyond the bank wrap around; the map is fixed at elaboration.
  for (genvar g = 0; g < 16; g++) begin : g_sema_map
    assign sema_map[g] = SW'(g % NumSemaphores);
  end

  assign sema_in = sema_map[req_i.sema_id];

  assign stat_o.scan_last = (32'(idx_q) == NumThreads - 1);
  assign age   = arrival_q - wstamp_q[idx_q];
  assign match = wvalid_q[idx_q] && (wsema_q[idx_q] == sema_q);
  assign better = match && (!found_q || wprio_q[idx_q] > best_prio_q ||
                  (wprio_q[idx_q] == best_prio_q && age > best_age_q));
  assign has_slot = (32'(tid_q) < NumThreads);
  assign cur = cnt_q[sema_q];
  assign init_sat = (CountBits >= 16) ? CountBits'(init_q) :
                    ((init_q > 16'(CountMax)) ? CountMax : CountBits'(init_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= req_i.command;
      sema_q <= sema_in;
      tid_q  <= req_i.thread_id;
      prio_q <= PriorityBits'(req_i.priority_req);
      init_q <= req_i.init_value;
    end
    if (cmd_i.scan_init) idx_q <= '0;
    else if (cmd_i.scan_step) idx_q <= idx_q + 1'b1;
    if (cmd_i.scan_step && better) begin
      best_q      <= idx_q;
      best_prio_q <= wprio_q[idx_q];
      best_age_q  <= age;
    end
    if (cmd_i.commit && cmd_q == CMD_DOWN && cur == '0 && has_slot) begin
      wsema_q [TW'(tid_q)] <= sema_q;
      wprio_q [TW'(tid_q)] <= prio_q;
      wstamp_q[TW'(tid_q)] <= arrival_q;
    end
    if (cmd_i.commit && cmd_q == CMD_PRIO && has_slot && wvalid_q[TW'(tid_q)])
      wprio_q[TW'(tid_q)] <= prio_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      wvalid_q  <= '0;
      arrival_q <= '0;
      for (int i = 0; i < NumSemaphores; i++) cnt_q[i] <= '0;
    end else begin
      if (cmd_i.scan_init) found_q <= 1'b0;
      else if (cmd_i.scan_step && better) found_q <= 1'b1;
      if (cmd_i.commit) begin
        case (cmd_q)
          CMD_INIT: begin
            cnt_q[sema_q] <= init_sat;
            for (int i = 0; i < NumThreads; i++)
              if (wsema_q[i] == sema_q) wvalid_q[i] <= 1'b0;
          end
          CMD_DOWN: begin
            if (cur != '0) cnt_q[sema_q] <= cur - 1'b1;
            else if (has_slot) begin
              wvalid_q[TW'(tid_q)] <= 1'b1;
              arrival_q <= arrival_q + 32'd1;
            end
          end
          CMD_TRY_DOWN: if (cur != '0) cnt_q[sema_q] <= cur - 1'b1;
          CMD_UP: begin
            if (cur != CountMax) cnt_q[sema_q] <= cur + 1'b1;
            if (found_q) wvalid_q[best_q] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Response, built at commit from the pre-commit state.
  always_comb begin
    rsp_d = '0;
    rsp_d.count_after = 16'(cur);
    case (cmd_q)
      CMD_INIT: begin
        rsp_d.status      = ST_INITIALIZED;
        rsp_d.count_after = 16'(init_sat);
      end
      CMD_DOWN, CMD_TRY_DOWN: begin
        if (cur != '0) begin
          rsp_d.status      = ST_ACQUIRED;
          rsp_d.count_after = 16'(cur - 1'b1);
        end else if (cmd_q == CMD_TRY_DOWN) rsp_d.status = ST_TRY_FAILED;
        else if (!has_slot) rsp_d.status = ST_QUEUE_FULL;
        else rsp_d.status = ST_QUEUED;
      end
      CMD_UP: begin
        rsp_d.count_after = (cur == CountMax) ? 16'(cur) : 16'(cur + 1'b1);
        if (found_q) begin
          rsp_d.status         = ST_UP_WOKE;
          rsp_d.woken_thread   = 5'(best_q);
          rsp_d.woken_priority = 6'(best_prio_q);
          rsp_d.preempt        = best_prio_q > prio_q;
        end else rsp_d.status = ST_UP_NO_WAITER;
        if (cur == CountMax) rsp_d.status = ST_UP_SATURATED;
      end
      CMD_PRIO: rsp_d.status = (has_slot && wvalid_q[TW'(tid_q)]) ?
                               ST_PRIO_UPDATED : ST_NOT_WAITING;
      default: rsp_d.status = ST_NOT_WAITING;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

  a_best_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && cmd_q == CMD_UP && found_q) |-> wvalid_q[best_q])
    else $error("chosen waiter not valid");
  a_arrival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (arrival_q != $past(arrival_q)) |-> $past(cmd_i.commit))
    else $error("arrival counter moved outside commit");
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_init |=> (idx_q == '0)) else $error("scan index not cleared");

endmodule

// ===== rtl/priority_semaphore_bank_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_semaphore_bank_top: counting semaphores with priority waiters.
// Channels: request items enter on in_valid_i/in_stall_o/in_data_i and
// response items leave on out_valid_o/out_stall_i/out_data_o. An item is
// taken at a rising edge where valid is high and stall is low.
// Every request gives exactly one response. After acceptance the block
// walks the waiter slots one per cycle for the best-waiter scan, then
// commits and presents the response. Items are handled one at a time,
// so a new request is not taken before the previous response is taken;
// the serial walk over the waiter table sets the pace.
// The response stays on out_data_o while out_stall_i is high; a new request
// is taken in the same cycle its predecessor's response is taken.
// Reset clears all counts, waiter valid bits and the arrival counter at
// once; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module priority_semaphore_bank_top #(
  parameter int unsigned NumSemaphores = psb_pkg::NumSemaphoresDef,
  parameter int unsigned NumThreads    = psb_pkg::NumThreadsDef,
  parameter int unsigned PriorityBits  = psb_pkg::PriorityBitsDef,
  parameter int unsigned CountBits     = psb_pkg::CountBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  psb_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output psb_pkg::rsp_t out_data_o
);
  import psb_pkg::*;

  psb_cmd_t  cmd;
  psb_stat_t stat;

  psb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  psb_dp #(
    .NumSemaphores(NumSemaphores), .NumThreads(NumThreads),
    .PriorityBits(PriorityBits), .CountBits(CountBits)
  ) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .stat_o(stat),
    .rsp_o(out_data_o)
  );

endmodule
